// ----- rtl/dipp_pkg.sv -----
// shared types, widths and constants for the depth image point projector
// no dependencies; every file but the two channel interfaces imports this package
package dipp_pkg;

  // frame and source image limits
  localparam int FRAME_SIZE    = 2048;
  localparam int MAX_IMAGE_DIM = 2048;

  // divide by 100 as multiply by ceil(2^30 / 100) and shift, exact below 2^23
  localparam int          RECIP_SH = 30;
  localparam logic [23:0] RECIP_M  = 24'd10737419;

  // datapath widths
  localparam int XW  = 13;  // world x, unsigned
  localparam int YW  = 15;  // world y, unsigned
  localparam int ZW  = 18;  // world z, signed
  localparam int RPW = 47;  // reciprocal product
  localparam int P1W = 34;  // first products and their sums
  localparam int P2W = 48;  // second products, viewer y
  localparam int ZVW = 53;  // viewer z
  localparam int FXW = 47;  // focal times viewer x
  localparam int NW  = 61;  // signed numerators
  localparam int AW  = 60;  // folded numerators
  localparam int DW  = 52;  // divisor
  localparam int QB  = 13;  // quotient bits
  localparam int SW  = 15;  // screen coordinate before the range check

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_SIN_AZ   = 3'd0,
    REG_COS_AZ   = 3'd1,
    REG_SIN_EL   = 3'd2,
    REG_COS_EL   = 3'd3,
    REG_VIEW_D   = 3'd4,
    REG_FOCAL    = 3'd5,
    REG_IMG_COLS = 3'd6,
    REG_SCR_CTR  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] sin_az;
    logic signed [15:0] cos_az;
    logic signed [15:0] sin_el;
    logic signed [15:0] cos_el;
    logic        [15:0] view_dist;
    logic        [11:0] focal;
    logic        [11:0] img_cols;
    logic signed [11:0] scr_ctr;
  } cfg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    logic [7:0]  gray;
    color_t      color;
  } pix_t;

  typedef struct packed {
    logic [XW-1:0]        x;
    logic [YW-1:0]        y;
    logic signed [ZW-1:0] z;
    color_t               color;
  } world_t;

  typedef struct packed {
    logic signed [P1W-1:0] xv;
    logic signed [P2W-1:0] yv;
    logic signed [ZVW-1:0] zv;
    color_t                color;
  } view_t;

  typedef struct packed {
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
    logic          negx;
    logic          negy;
    logic [DW-1:0] d;
    logic          behind;
    color_t        color;
  } frac_t;

  typedef struct packed {
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic          behind;
    color_t        color;
  } quot_t;

endpackage

// ----- rtl/dipp_pix_if.sv -----
// pixel input channel: valid/ready handshake with the source pixel fields
// no dependencies
interface dipp_pix_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_col;
  logic [10:0] pixel_row;
  logic [7:0]  depth_gray;
  logic [7:0]  blue_in;
  logic [7:0]  green_in;
  logic [7:0]  red_in;

  modport source (output valid, pixel_col, pixel_row, depth_gray, blue_in, green_in,
                  red_in, input ready);
  modport sink (input valid, pixel_col, pixel_row, depth_gray, blue_in, green_in,
                red_in, output ready);
endinterface

// ----- rtl/dipp_pt_if.sv -----
// projected point output channel: valid/ready handshake with screen fields
// no dependencies
interface dipp_pt_if;
  logic        valid;
  logic        ready;
  logic [10:0] screen_x;
  logic [10:0] screen_y;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;
  logic        on_screen;

  modport source (output valid, screen_x, screen_y, blue_out, green_out, red_out,
                  on_screen, input ready);
  modport sink (input valid, screen_x, screen_y, blue_out, green_out, red_out,
                on_screen, output ready);
endinterface

// ----- rtl/depth_image_point_projector.sv -----
// depth image point projector, fully pipelined from input beat to output beat
// (2 world, 4 viewing, 3 scaling, 14 divider, 1 output register stages);
// one beat per cycle while not stalled; divider one bit a stage after the first
// reset empties the pipeline and loads the default eye registers
// depends on dipp_pkg, dipp_pix_if, dipp_pt_if and the dipp_* stage modules
module depth_image_point_projector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  dipp_pix_if.sink    pix_i,
  dipp_pt_if.source   pt_o
);
  import dipp_pkg::*;

  cfg_t   cfg_q;
  pix_t   pix;
  world_t world;
  view_t  view;
  frac_t  frac;
  quot_t  quot;

  logic world_v, world_r;
  logic view_v, view_r;
  logic frac_v, frac_r;
  logic quot_v, quot_r;

  logic signed [QB:0]   qxs, qys;
  logic signed [SW-1:0] px, py;
  logic                 vis;

  logic        out_v_q;
  logic [10:0] sx_q, sy_q;
  color_t      col_q;
  logic        on_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sin_az    <= 16'sd11585;
      cfg_q.cos_az    <= 16'sd11585;
      cfg_q.sin_el    <= 16'sd13377;
      cfg_q.cos_el    <= 16'sd9459;
      cfg_q.view_dist <= 16'd346;
      cfg_q.focal     <= 12'd1000;
      cfg_q.img_cols  <= 12'd640;
      cfg_q.scr_ctr   <= 12'sd724;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SIN_AZ:   cfg_q.sin_az    <= $signed(cfg_wdata_i);
        REG_COS_AZ:   cfg_q.cos_az    <= $signed(cfg_wdata_i);
        REG_SIN_EL:   cfg_q.sin_el    <= $signed(cfg_wdata_i);
        REG_COS_EL:   cfg_q.cos_el    <= $signed(cfg_wdata_i);
        REG_VIEW_D:   cfg_q.view_dist <= cfg_wdata_i;
        REG_FOCAL:    cfg_q.focal     <= cfg_wdata_i[11:0];
        REG_IMG_COLS: cfg_q.img_cols  <= cfg_wdata_i[11:0];
        REG_SCR_CTR:  cfg_q.scr_ctr   <= $signed(cfg_wdata_i[11:0]);
        default: ;
      endcase
    end
  end

  // input beat into the internal struct
  assign pix.col         = pix_i.pixel_col;
  assign pix.row         = pix_i.pixel_row;
  assign pix.gray        = pix_i.depth_gray;
  assign pix.color.blue  = pix_i.blue_in;
  assign pix.color.green = pix_i.green_in;
  assign pix.color.red   = pix_i.red_in;

  dipp_world u_world (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .pix_i       (pix),
    .out_valid_o (world_v),
    .out_ready_i (world_r),
    .world_o     (world)
  );

  dipp_view u_view (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (world_v),
    .in_ready_o  (world_r),
    .world_i     (world),
    .out_valid_o (view_v),
    .out_ready_i (view_r),
    .view_o      (view)
  );

  dipp_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (view_v),
    .in_ready_o  (view_r),
    .view_i      (view),
    .out_valid_o (frac_v),
    .out_ready_i (frac_r),
    .frac_o      (frac)
  );

  dipp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frac_v),
    .in_ready_o  (frac_r),
    .frac_i      (frac),
    .out_valid_o (quot_v),
    .out_ready_i (quot_r),
    .quot_o      (quot)
  );

  // unfold the quotient signs, add the centre offset and check the frame
  always_comb begin
    qxs = quot.negx ? $signed(~{1'b0, quot.qx}) : $signed({1'b0, quot.qx});
    qys = quot.negy ? $signed(~{1'b0, quot.qy}) : $signed({1'b0, quot.qy});
    px  = SW'(cfg_q.scr_ctr) + SW'(qxs);
    py  = SW'(cfg_q.scr_ctr) + SW'(qys);
    vis = !quot.behind && !quot.ovfx && !quot.ovfy
          && !px[SW-1] && (px < SW'(FRAME_SIZE))
          && !py[SW-1] && (py < SW'(FRAME_SIZE));
  end

  // output register
  assign quot_r = !out_v_q || pt_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (quot_r) begin
      out_v_q <= quot_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quot_r) begin
      sx_q  <= vis ? px[10:0] : '0;
      sy_q  <= vis ? py[10:0] : '0;
      col_q <= quot.color;
      on_q  <= vis;
    end
  end

  assign pt_o.valid     = out_v_q;
  assign pt_o.screen_x  = sx_q;
  assign pt_o.screen_y  = sy_q;
  assign pt_o.blue_out  = col_q.blue;
  assign pt_o.green_out = col_q.green;
  assign pt_o.red_out   = col_q.red;
  assign pt_o.on_screen = on_q;

`ifndef SYNTH
  // a drained or moving output stage lets the whole pipeline take a beat
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pt_o.valid || pt_o.ready) |-> pix_i.ready)
    else $error("input not ready although output stage can move");

  // an off-frame point reports zero coordinates
  a_off_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && !pt_o.on_screen) |-> (pt_o.screen_x == '0 && pt_o.screen_y == '0))
    else $error("off-frame point with non-zero coordinates");

  // nothing leaves the block while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !pt_o.valid)
    else $error("output beat during reset");
`endif

endmodule

// ----- rtl/dipp_world.sv -----
// world point builder: pixel to fixed point x, y, z, two stages
// depends on dipp_pkg
module dipp_world (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dipp_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dipp_pkg::pix_t         pix_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dipp_pkg::world_t       world_o
);
  import dipp_pkg::*;

  localparam int NS = 2;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS-1:0] en;

  logic [12:0]           cols;
  logic signed [13:0]    dz;
  logic signed [24:0]    dz_ext;
  logic signed [24:0]    nz;
  logic [22:0]           yn;
  logic [22:0]           zn;

  logic [XW-1:0]         x1_q;
  logic [RPW-1:0]        yp1_q;
  logic [RPW-1:0]        zp1_q;
  logic                  zneg1_q;
  color_t                col1_q;

  logic [ZW-1:0]         zq;
  world_t                w2_q;

  // stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // stage 1: clamp width, scale row and column, multiply by reciprocal of 100
  always_comb begin
    if ({1'b0, cfg_i.img_cols} > 13'(MAX_IMAGE_DIM)) begin
      cols = 13'(MAX_IMAGE_DIM);
    end else begin
      cols = {1'b0, cfg_i.img_cols};
    end
    dz     = $signed({1'b0, cols}) - $signed({3'b000, pix_i.row});
    dz_ext = {{11{dz[13]}}, dz};
    nz     = (dz_ext <<< 11) - (dz_ext <<< 8) + 25'sd50;
    // floor of a negative value through the complement
    zn     = nz[24] ? 23'(~nz) : 23'(nz);
    yn     = 23'({pix_i.col, 10'b0}) + 23'd50;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x1_q    <= {~pix_i.gray, 5'b0};
      yp1_q   <= RPW'(yn) * RPW'(RECIP_M);
      zp1_q   <= RPW'(zn) * RPW'(RECIP_M);
      zneg1_q <= nz[24];
      col1_q  <= pix_i.color;
    end
  end

  // stage 2: take the quotients and restore the sign of z
  assign zq = ZW'(zp1_q >> RECIP_SH);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      w2_q.x     <= x1_q;
      w2_q.y     <= YW'(yp1_q >> RECIP_SH);
      w2_q.z     <= zneg1_q ? $signed(~zq) : $signed(zq);
      w2_q.color <= col1_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign world_o     = w2_q;

endmodule

// ----- rtl/dipp_view.sv -----
// viewing transform: rotate the world point into viewer coordinates, four stages
// depends on dipp_pkg
module dipp_view (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dipp_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dipp_pkg::world_t       world_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dipp_pkg::view_t        view_o
);
  import dipp_pkg::*;

  localparam int NS = 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS-1:0] en;

  logic signed [XW:0] xs;
  logic signed [YW:0] ys;

  logic signed [P1W-1:0] sx3_q, cy3_q, cx3_q, sy3_q, sz3_q, cz3_q;
  color_t                col3_q;

  logic signed [P1W-1:0] w4_q, xv4_q, sz4_q, cz4_q;
  color_t                col4_q;

  logic signed [P2W-1:0] cw5_q, sw5_q;
  logic signed [P1W-1:0] xv5_q, sz5_q, cz5_q;
  color_t                col5_q;

  view_t                 v6_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign xs = $signed({1'b0, world_i.x});
  assign ys = $signed({1'b0, world_i.y});

  // stage 3: first products of the azimuth and elevation terms
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sx3_q  <= P1W'(cfg_i.sin_az) * P1W'(xs);
      cy3_q  <= P1W'(cfg_i.cos_az) * P1W'(ys);
      cx3_q  <= P1W'(cfg_i.cos_az) * P1W'(xs);
      sy3_q  <= P1W'(cfg_i.sin_az) * P1W'(ys);
      sz3_q  <= P1W'(cfg_i.sin_el) * P1W'(world_i.z);
      cz3_q  <= P1W'(cfg_i.cos_el) * P1W'(world_i.z);
      col3_q <= world_i.color;
    end
  end

  // stage 4: shared azimuth sum and viewer x
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      w4_q   <= cx3_q + sy3_q;
      xv4_q  <= cy3_q - sx3_q;
      sz4_q  <= sz3_q;
      cz4_q  <= cz3_q;
      col4_q <= col3_q;
    end
  end

  // stage 5: elevation products of the azimuth sum
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      cw5_q  <= P2W'(cfg_i.cos_el) * P2W'(w4_q);
      sw5_q  <= P2W'(cfg_i.sin_el) * P2W'(w4_q);
      xv5_q  <= xv4_q;
      sz5_q  <= sz4_q;
      cz5_q  <= cz4_q;
      col5_q <= col4_q;
    end
  end

  // stage 6: viewer y and z, z carries the eye distance
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      v6_q.xv    <= xv5_q;
      v6_q.yv    <= (P2W'(sz5_q) <<< 14) - cw5_q;
      v6_q.zv    <= (ZVW'($signed({1'b0, cfg_i.view_dist})) <<< 34)
                    - (ZVW'(cz5_q) <<< 14) - ZVW'(sw5_q);
      v6_q.color <= col5_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign view_o      = v6_q;

endmodule

// ----- rtl/dipp_scale.sv -----
// focal scaling and sign folding of the numerators, three stages
// depends on dipp_pkg
module dipp_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dipp_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dipp_pkg::view_t        view_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dipp_pkg::frac_t        frac_o
);
  import dipp_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS-1:0] en;

  logic signed [12:0]    fs;

  logic signed [FXW-1:0] fx7_q;
  logic signed [36:0]    fhi7_q;
  logic [35:0]           flo7_q;
  logic signed [ZVW-1:0] zv7_q;
  color_t                col7_q;

  logic signed [NW-1:0]  nx8_q;
  logic signed [NW-1:0]  py8_q;
  logic signed [ZVW-1:0] zv8_q;
  color_t                col8_q;

  logic                  negy;
  frac_t                 f9_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  assign fs = $signed({1'b0, cfg_i.focal});

  // stage 7: focal products, viewer y split in two halves
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      fx7_q  <= FXW'(fs) * FXW'(view_i.xv);
      fhi7_q <= 37'(fs) * 37'($signed(view_i.yv[47:24]));
      flo7_q <= 36'(cfg_i.focal) * 36'(view_i.yv[23:0]);
      zv7_q  <= view_i.zv;
      col7_q <= view_i.color;
    end
  end

  // stage 8: full width numerators, y still positive-signed product
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      nx8_q  <= NW'(fx7_q) <<< 14;
      py8_q  <= (NW'(fhi7_q) <<< 24) + $signed(NW'(flo7_q));
      zv8_q  <= zv7_q;
      col8_q <= col7_q;
    end
  end

  // stage 9: fold negative numerators so floor becomes a plain unsigned divide
  assign negy = !py8_q[NW-1] && (py8_q != '0);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      f9_q.negx   <= nx8_q[NW-1];
      f9_q.ax     <= nx8_q[NW-1] ? AW'(~nx8_q) : AW'(nx8_q);
      f9_q.negy   <= negy;
      f9_q.ay     <= negy ? AW'(py8_q - NW'(1)) : AW'(-py8_q);
      f9_q.d      <= DW'(zv8_q);
      f9_q.behind <= zv8_q[ZVW-1] || (zv8_q == '0);
      f9_q.color  <= col8_q;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];
  assign frac_o      = f9_q;

endmodule

// ----- rtl/dipp_div.sv -----
// pipelined restoring divider for both screen axes, one quotient bit a stage after the first
// depends on dipp_pkg
module dipp_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dipp_pkg::frac_t        frac_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output dipp_pkg::quot_t        quot_o
);
  import dipp_pkg::*;

  localparam int NS = QB + 1;
  localparam int RW = DW + QB;

  typedef struct packed {
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [DW-1:0] d;
    logic          negx;
    logic          negy;
    logic          ovfx;
    logic          ovfy;
    logic          behind;
    color_t        color;
  } div_t;

  logic [NS-1:0] v_q;
  logic [NS-1:0] v_in;
  logic [NS-1:0] en;

  div_t stg_d [NS];
  div_t stg_q [NS];

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_in = {v_q[NS-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // first stage: a quotient of more than QB bits is out of any frame
  always_comb begin
    stg_d[0].rx     = RW'(frac_i.ax);
    stg_d[0].ry     = RW'(frac_i.ay);
    stg_d[0].qx     = '0;
    stg_d[0].qy     = '0;
    stg_d[0].d      = frac_i.d;
    stg_d[0].negx   = frac_i.negx;
    stg_d[0].negy   = frac_i.negy;
    stg_d[0].ovfx   = RW'(frac_i.ax) >= {frac_i.d, QB'(0)};
    stg_d[0].ovfy   = RW'(frac_i.ay) >= {frac_i.d, QB'(0)};
    stg_d[0].behind = frac_i.behind;
    stg_d[0].color  = frac_i.color;
  end

  // remaining stages: compare and subtract the divisor shifted to this bit
  for (genvar k = 1; k < NS; k++) begin : g_bit
    logic [RW-1:0] dsh;
    always_comb begin
      dsh        = RW'(stg_q[k-1].d) << (QB - k);
      stg_d[k]   = stg_q[k-1];
      if (stg_q[k-1].rx >= dsh) begin
        stg_d[k].rx        = stg_q[k-1].rx - dsh;
        stg_d[k].qx[QB-k]  = 1'b1;
      end
      if (stg_q[k-1].ry >= dsh) begin
        stg_d[k].ry        = stg_q[k-1].ry - dsh;
        stg_d[k].qy[QB-k]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_ready_o    = en[0];
  assign out_valid_o   = v_q[NS-1];
  assign quot_o.qx     = stg_q[NS-1].qx;
  assign quot_o.qy     = stg_q[NS-1].qy;
  assign quot_o.negx   = stg_q[NS-1].negx;
  assign quot_o.negy   = stg_q[NS-1].negy;
  assign quot_o.ovfx   = stg_q[NS-1].ovfx;
  assign quot_o.ovfy   = stg_q[NS-1].ovfy;
  assign quot_o.behind = stg_q[NS-1].behind;
  assign quot_o.color  = stg_q[NS-1].color;

endmodule

// ----- dv/dipp_point_checker.sv -----
`timescale 1ns / 1ps
// point checker: watches the config port and both channels, predicts each projected point
// depends on dipp_pkg, dipp_pix_if and dipp_pt_if
module dipp_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  dipp_pix_if         pix,
  dipp_pt_if          pt,
  output int          fail_count_o,
  output int          pending_o
);
  import dipp_pkg::*;

  typedef struct packed {
    logic [10:0] sx;
    logic [10:0] sy;
    color_t      color;
    logic        vis;
  } point_t;

  cfg_t   eye_cfg;
  point_t point_q[$];
  int     fails;

  assign fail_count_o = fails;
  assign pending_o    = point_q.size();

  // floor division, divisor positive
  function automatic longint div_down(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // world point, viewing transform, perspective divide and frame check
  function automatic point_t project_pixel(pix_t p);
    longint sa, ca, se, ce, cols, x, y, z, xv, yv, zv, px, py;
    logic   vis;
    point_t r;
    sa   = longint'($signed(eye_cfg.sin_az));
    ca   = longint'($signed(eye_cfg.cos_az));
    se   = longint'($signed(eye_cfg.sin_el));
    ce   = longint'($signed(eye_cfg.cos_el));
    cols = (eye_cfg.img_cols > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : longint'(eye_cfg.img_cols);
    x  = (255 - longint'(p.gray)) * 32;
    y  = (longint'(p.col) * 1024 + 50) / 100;
    z  = div_down((cols - longint'(p.row)) * 1792 + 50, 100);
    xv = (-sa * x + ca * y) * 16384;
    yv = -ca * ce * x - ce * sa * y + se * z * 16384;
    zv = -se * ca * x - se * sa * y - ce * z * 16384
         + longint'(eye_cfg.view_dist) * (64'sd1 <<< 34);
    px  = 0;
    py  = 0;
    vis = 1'b0;
    if (zv > 0) begin
      px  = longint'($signed(eye_cfg.scr_ctr)) + div_down(longint'(eye_cfg.focal) * xv, zv);
      py  = longint'($signed(eye_cfg.scr_ctr)) + div_down(-(longint'(eye_cfg.focal) * yv), zv);
      vis = px >= 0 && px < FRAME_SIZE && py >= 0 && py < FRAME_SIZE;
    end
    if (!vis) begin
      px = 0;
      py = 0;
    end
    r.sx    = px[10:0];
    r.sy    = py[10:0];
    r.color = p.color;
    r.vis   = vis;
    return r;
  endfunction

  // register copy, prediction on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    pix_t   p;
    point_t e;
    point_t a;
    if (!rst_ni) begin
      eye_cfg <= '{sin_az: 16'sd11585, cos_az: 16'sd11585, sin_el: 16'sd13377,
                   cos_el: 16'sd9459, view_dist: 16'd346, focal: 12'd1000,
                   img_cols: 12'd640, scr_ctr: 12'sd724};
      point_q.delete();
      fails <= 0;
    end else begin
      if (pix.valid && pix.ready) begin
        p = '{col: pix.pixel_col, row: pix.pixel_row, gray: pix.depth_gray,
              color: '{blue: pix.blue_in, green: pix.green_in, red: pix.red_in}};
        point_q.push_back(project_pixel(p));
      end
      if (pt.valid && pt.ready) begin
        a = '{sx: pt.screen_x, sy: pt.screen_y,
              color: '{blue: pt.blue_out, green: pt.green_out, red: pt.red_out},
              vis: pt.on_screen};
        if (point_q.size() == 0) begin
          $display("%0t: unexpected point beat, got %p", $realtime, a);
          fails <= fails + 1;
        end else begin
          e = point_q.pop_front();
          if (a.sx !== e.sx || a.sy !== e.sy || a.color !== e.color || a.vis !== e.vis) begin
            $display("%0t: point mismatch", $realtime);
            if (a.sx !== e.sx) $display("  screen_x exp %0d got %0d", e.sx, a.sx);
            if (a.sy !== e.sy) $display("  screen_y exp %0d got %0d", e.sy, a.sy);
            if (a.color !== e.color) $display("  color exp %h got %h", e.color, a.color);
            if (a.vis !== e.vis) $display("  on_screen exp %0b got %0b", e.vis, a.vis);
            fails <= fails + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_SIN_AZ:   eye_cfg.sin_az    <= cfg_wdata_i;
          REG_COS_AZ:   eye_cfg.cos_az    <= cfg_wdata_i;
          REG_SIN_EL:   eye_cfg.sin_el    <= cfg_wdata_i;
          REG_COS_EL:   eye_cfg.cos_el    <= cfg_wdata_i;
          REG_VIEW_D:   eye_cfg.view_dist <= cfg_wdata_i;
          REG_FOCAL:    eye_cfg.focal     <= cfg_wdata_i[11:0];
          REG_IMG_COLS: eye_cfg.img_cols  <= cfg_wdata_i[11:0];
          REG_SCR_CTR:  eye_cfg.scr_ctr   <= cfg_wdata_i[11:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- dv/depth_image_point_projector_tb.sv -----
`timescale 1ns / 1ps
// top of the point projector bench: clock, reset, eye settings, pixel stimulus, verdict
// depends on dipp_pkg, the channel interfaces, dipp_point_checker and the block
module depth_image_point_projector_tb;
  import dipp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  int          idle_pct;
  int          stall_pct;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  dipp_pix_if pix ();
  dipp_pt_if  pt ();

  depth_image_point_projector DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .pix_i(pix), .pt_o(pt)
  );

  dipp_point_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_wdata_i(cfg_wdata), .pix(pix), .pt(pt),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #4 clk_i = ~clk_i;

  // receiver stalls
  always @(posedge clk_i) pt.ready <= ($urandom_range(99) >= stall_pct);

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(logic [10:0] col, logic [10:0] row, logic [7:0] gray,
                            logic [23:0] bgr);
    logic got;
    while ($urandom_range(99) < idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid      <= 1'b1;
    pix.pixel_col  <= col;
    pix.pixel_row  <= row;
    pix.depth_gray <= gray;
    {pix.blue_in, pix.green_in, pix.red_in} <= bgr;
    do begin
      @(negedge clk_i);
      got = pix.ready;
      @(posedge clk_i);
    end while (!got);
  endtask

  task automatic drain;
    pix.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // pick an 11-bit value, often at an extreme
  function automatic logic [10:0] pick11();
    case ($urandom_range(9))
      0: return 11'd0;
      1: return 11'd2047;
      2, 3, 4: return 11'($urandom_range(700));
      default: return 11'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_trig();
    case ($urandom_range(7))
      0: return 16'sh4000;
      1: return -16'sh4000;
      2: return 16'd0;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic random_eye(int k);
    write_reg(REG_SIN_AZ, pick_trig());
    write_reg(REG_COS_AZ, pick_trig());
    write_reg(REG_SIN_EL, pick_trig());
    write_reg(REG_COS_EL, pick_trig());
    write_reg(REG_VIEW_D, (k % 2) ? 16'($urandom_range(200, 2000))
                                  : 16'($urandom_range(1, 65535)));
    write_reg(REG_FOCAL, 16'($urandom_range(4095)));
    write_reg(REG_IMG_COLS, 16'($urandom_range(4095)));
    write_reg(REG_SCR_CTR, 16'($urandom_range(4095)));
  endtask

  task automatic random_pixels(int n);
    repeat (n) send_pixel(pick11(), pick11(), 8'($urandom), 24'($urandom));
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_SIN_AZ;
    cfg_wdata <= '0;
    pix.valid <= 1'b0;
    pix.pixel_col <= '0;
    pix.pixel_row <= '0;
    pix.depth_gray <= '0;
    pix.blue_in <= '0;
    pix.green_in <= '0;
    pix.red_in <= '0;
    // a real falling edge so the asynchronous reset takes hold before the first clock
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and two mid-range pixels under the default eye
    send_pixel(11'd0, 11'd0, 8'd0, 24'h000000);
    send_pixel(11'd2047, 11'd2047, 8'd255, 24'hFFFFFF);
    send_pixel(11'd0, 11'd2047, 8'd255, 24'h123456);
    send_pixel(11'd2047, 11'd0, 8'd0, 24'hABCDEF);
    send_pixel(11'd320, 11'd240, 8'd128, 24'h55AA55);
    send_pixel(11'd100, 11'd640, 8'd200, 24'hAA55AA);
    drain();

    // extremes, with image width above the saturation limit
    write_reg(REG_SIN_AZ, -16'sh4000);
    write_reg(REG_COS_AZ, 16'sh4000);
    write_reg(REG_SIN_EL, 16'sh4000);
    write_reg(REG_COS_EL, -16'sh4000);
    write_reg(REG_VIEW_D, 16'd65535);
    write_reg(REG_FOCAL, 16'd4095);
    write_reg(REG_IMG_COLS, 16'd4095);
    write_reg(REG_SCR_CTR, 16'hF800);
    send_pixel(11'd0, 11'd0, 8'd0, 24'h010203);
    send_pixel(11'd2047, 11'd2047, 8'd255, 24'h040506);
    send_pixel(11'd1024, 11'd0, 8'd7, 24'h070809);
    drain();

    // eye behind the points, zero focal length, zero image width
    write_reg(REG_SIN_AZ, 16'd0);
    write_reg(REG_COS_EL, 16'd0);
    write_reg(REG_VIEW_D, 16'd1);
    write_reg(REG_FOCAL, 16'd0);
    write_reg(REG_IMG_COLS, 16'd0);
    write_reg(REG_SCR_CTR, 16'd2047);
    send_pixel(11'd0, 11'd0, 8'd0, 24'hFF00FF);
    send_pixel(11'd5, 11'd9, 8'd255, 24'h00FF00);
    drain();
    write_reg(REG_VIEW_D, 16'd2000);
    send_pixel(11'd0, 11'd0, 8'd0, 24'h0F0F0F);
    send_pixel(11'd2047, 11'd2047, 8'd128, 24'hF0F0F0);
    drain();

    // random phases under every idle and stall mode
    for (int k = 0; k < 8; k++) begin
      case (k % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      random_eye(k);
      random_pixels(175);
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/dipp_pkg.sv
rtl/dipp_pix_if.sv
rtl/dipp_pt_if.sv
rtl/dipp_world.sv
rtl/dipp_view.sv
rtl/dipp_scale.sv
rtl/dipp_div.sv
rtl/depth_image_point_projector.sv
dv/dipp_point_checker.sv
dv/depth_image_point_projector_tb.sv
